[design/array_linked_list_engine_macros.svh]
// Assertion macros shared by the linked list engine modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ARRAY_LINKED_LIST_ENGINE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, held off during reset
`define ALLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/alle_pkg.sv]
// Package for the linked list engine: word types, codes, microword layout,
// the control store and the command dispatch table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

    localparam int LINK_W = 7;
    localparam logic [LINK_W-1:0] NULL_LINK = 7'h7F;

    // commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] item_value;
        logic [6:0]        position;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]        status;
        logic              last_of_run;
    } t_out_word;

    // microword fields
    typedef enum logic [1:0] {J_NEXT, J_GOTO, J_SKIP, J_LOOP} t_jmode;
    typedef enum logic [2:0] {
        C_FULL, C_TNULL, C_NXTNULL, C_POS0, C_WALK_END, C_LAST
    } t_cond;
    typedef enum logic [1:0] {T_KEEP, T_HEAD, T_LINK} t_tsel;
    typedef enum logic [1:0] {WR_NONE, WR_NODE, WR_LINK} t_wr;
    typedef enum logic [1:0] {L_NULL, L_HEAD, L_RL, L_SLOT} t_lsrc;
    typedef enum logic [1:0] {H_KEEP, H_SLOT, H_RL} t_hsel;
    typedef enum logic [1:0] {E_NONE, E_STAT, E_ELEM} t_emit;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_jmode     jmode;
        t_cond      cond;
        t_upc       tgt;
        t_tsel      t_sel;
        logic       cnt_inc;
        logic       pv_load;
        t_wr        wr;
        logic       wa_pv;
        t_lsrc      lsrc;
        t_hsel      h_sel;
        logic       alloc_inc;
        t_emit      emit;
        logic [1:0] status;
        logic       last;
    } t_uword;

    typedef struct packed {
        logic   accept;
        logic   do_ops;
        t_uword uw;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic tnull;
        logic nxtnull;
        logic pos0;
        logic walk_end;
        logic last;
        logic out_free;
    } t_flags;

    // control store addresses
    localparam t_upc U_IDLE   = 5'd0;
    localparam t_upc U_A0     = 5'd1;
    localparam t_upc U_A1     = 5'd2;
    localparam t_upc U_A2     = 5'd3;
    localparam t_upc U_ATAIL  = 5'd4;
    localparam t_upc U_ALINK  = 5'd5;
    localparam t_upc U_AHEAD  = 5'd6;
    localparam t_upc U_I0     = 5'd7;
    localparam t_upc U_I1     = 5'd8;
    localparam t_upc U_I2     = 5'd9;
    localparam t_upc U_I3     = 5'd10;
    localparam t_upc U_I4     = 5'd11;
    localparam t_upc U_I5     = 5'd12;
    localparam t_upc U_IFRONT = 5'd13;
    localparam t_upc U_D0     = 5'd14;
    localparam t_upc U_D1     = 5'd15;
    localparam t_upc U_D2     = 5'd16;
    localparam t_upc U_D3     = 5'd17;
    localparam t_upc U_D4     = 5'd18;
    localparam t_upc U_D5     = 5'd19;
    localparam t_upc U_DFRONT = 5'd20;
    localparam t_upc U_R0     = 5'd21;
    localparam t_upc U_R1     = 5'd22;
    localparam t_upc U_R2     = 5'd23;
    localparam t_upc U_EFULL  = 5'd24;
    localparam t_upc U_ERANGE = 5'd25;
    localparam t_upc U_EEMPTY = 5'd26;

    function automatic t_upc dispatch(input logic [1:0] cmd);
        t_upc a;
        case (cmd)
            CMD_APPEND: a = U_A0;
            CMD_INSERT: a = U_I0;
            CMD_DELETE: a = U_D0;
            CMD_READ:   a = U_R0;
            default:    a = U_IDLE;
        endcase
        return a;
    endfunction

    // control store; unlisted steps fall back to idle
    function automatic t_uword uw_rom(input t_upc a);
        t_uword w;
        w.jmode     = J_GOTO;
        w.cond      = C_FULL;
        w.tgt       = U_IDLE;
        w.t_sel     = T_KEEP;
        w.cnt_inc   = 1'b0;
        w.pv_load   = 1'b0;
        w.wr        = WR_NONE;
        w.wa_pv     = 1'b0;
        w.lsrc      = L_NULL;
        w.h_sel     = H_KEEP;
        w.alloc_inc = 1'b0;
        w.emit      = E_NONE;
        w.status    = ST_OK;
        w.last      = 1'b1;
        case (a)
            // append
            U_A0: begin
                w.jmode = J_SKIP; w.cond = C_FULL; w.tgt = U_EFULL;
            end
            U_A1: begin
                w.jmode = J_SKIP; w.cond = C_TNULL; w.tgt = U_AHEAD;
            end
            U_A2: begin
                w.jmode = J_LOOP; w.cond = C_NXTNULL; w.tgt = U_ATAIL;
                w.t_sel = T_LINK;
            end
            U_ATAIL: begin
                w.jmode = J_NEXT; w.wr = WR_NODE; w.lsrc = L_NULL;
            end
            U_ALINK: begin
                w.wr = WR_LINK; w.lsrc = L_SLOT; w.alloc_inc = 1'b1; w.emit = E_STAT;
            end
            U_AHEAD: begin
                w.wr = WR_NODE; w.lsrc = L_NULL; w.h_sel = H_SLOT;
                w.alloc_inc = 1'b1; w.emit = E_STAT;
            end
            // insert
            U_I0: begin
                w.jmode = J_SKIP; w.cond = C_FULL; w.tgt = U_EFULL;
            end
            U_I1: begin
                w.jmode = J_SKIP; w.cond = C_POS0; w.tgt = U_IFRONT;
            end
            U_I2: begin
                w.jmode = J_LOOP; w.cond = C_WALK_END; w.tgt = U_I3;
                w.t_sel = T_LINK; w.cnt_inc = 1'b1;
            end
            U_I3: begin
                w.jmode = J_SKIP; w.cond = C_TNULL; w.tgt = U_ERANGE;
            end
            U_I4: begin
                w.jmode = J_NEXT; w.wr = WR_NODE; w.lsrc = L_RL;
            end
            U_I5: begin
                w.wr = WR_LINK; w.lsrc = L_SLOT; w.alloc_inc = 1'b1; w.emit = E_STAT;
            end
            U_IFRONT: begin
                w.wr = WR_NODE; w.lsrc = L_HEAD; w.h_sel = H_SLOT;
                w.alloc_inc = 1'b1; w.emit = E_STAT;
            end
            // delete
            U_D0: begin
                w.jmode = J_SKIP; w.cond = C_TNULL; w.tgt = U_EEMPTY;
            end
            U_D1: begin
                w.jmode = J_SKIP; w.cond = C_POS0; w.tgt = U_DFRONT;
            end
            U_D2: begin
                w.jmode = J_LOOP; w.cond = C_WALK_END; w.tgt = U_D3;
                w.t_sel = T_LINK; w.cnt_inc = 1'b1;
            end
            U_D3: begin
                w.jmode = J_SKIP; w.cond = C_TNULL; w.tgt = U_ERANGE;
            end
            U_D4: begin
                w.jmode = J_SKIP; w.cond = C_NXTNULL; w.tgt = U_ERANGE;
                w.pv_load = 1'b1; w.t_sel = T_LINK;
            end
            U_D5: begin
                w.wr = WR_LINK; w.wa_pv = 1'b1; w.lsrc = L_RL; w.emit = E_STAT;
            end
            U_DFRONT: begin
                w.h_sel = H_RL; w.emit = E_STAT;
            end
            // read out
            U_R0: begin
                w.jmode = J_SKIP; w.cond = C_TNULL; w.tgt = U_EEMPTY;
            end
            U_R1: begin
                w.jmode = J_LOOP; w.cond = C_LAST; w.tgt = U_R2;
                w.emit = E_ELEM; w.last = 1'b0; w.t_sel = T_LINK; w.cnt_inc = 1'b1;
            end
            U_R2: begin
                w.emit = E_ELEM;
            end
            // error exits
            U_EFULL: begin
                w.emit = E_STAT; w.status = ST_FULL;
            end
            U_ERANGE: begin
                w.emit = E_STAT; w.status = ST_RANGE;
            end
            U_EEMPTY: begin
                w.emit = E_STAT; w.status = ST_EMPTY;
            end
            default: begin
                w.tgt = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/alle_seq.sv]
// Microcode sequencer: step counter, control store lookup, branch logic.
// Depends on alle_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "array_linked_list_engine_macros.svh"

module alle_seq
    import alle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd,
    input  wire t_flags     i_flags,
    output t_ctl            o_ctl,
    output logic            o_in_stall
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   cond_hit;
    logic   ops;

    always_comb begin
        uw = uw_rom(r_upc);
        case (uw.cond)
            C_FULL:     cond_hit = i_flags.full;
            C_TNULL:    cond_hit = i_flags.tnull;
            C_NXTNULL:  cond_hit = i_flags.nxtnull;
            C_POS0:     cond_hit = i_flags.pos0;
            C_WALK_END: cond_hit = i_flags.walk_end;
            C_LAST:     cond_hit = i_flags.last;
            default:    cond_hit = 1'b0;
        endcase

        ops   = 1'b0;
        n_upc = r_upc;
        if (r_upc == U_IDLE) begin
            if (i_in_valid) begin
                n_upc = dispatch(i_cmd);
            end
        end else begin
            case (uw.jmode)
                J_NEXT: begin
                    ops   = 1'b1;
                    n_upc = r_upc + t_upc'(1);
                end
                J_GOTO: begin
                    ops   = 1'b1;
                    n_upc = uw.tgt;
                end
                J_SKIP: begin
                    if (cond_hit) begin
                        n_upc = uw.tgt;
                    end else begin
                        ops   = 1'b1;
                        n_upc = r_upc + t_upc'(1);
                    end
                end
                J_LOOP: begin
                    if (cond_hit) begin
                        n_upc = uw.tgt;
                    end else begin
                        ops = 1'b1;
                    end
                end
                default: begin
                    n_upc = U_IDLE;
                end
            endcase
            // a result word waits for room in the output register
            if (ops && (uw.emit != E_NONE) && !i_flags.out_free) begin
                ops   = 1'b0;
                n_upc = r_upc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl.accept = (r_upc == U_IDLE) && i_in_valid;
    assign o_ctl.do_ops = ops;
    assign o_ctl.uw     = uw;
    assign o_in_stall   = (r_upc != U_IDLE);

    `ALLE_ASSERT_NOW(a_emit_has_room, o_ctl.do_ops && (o_ctl.uw.emit != E_NONE), i_flags.out_free, "result word issued with output register blocked")
    `ALLE_ASSERT_NEXT(a_status_ends_cmd, o_ctl.do_ops && (o_ctl.uw.emit == E_STAT), r_upc == U_IDLE, "command did not finish after its status word")

endmodule

`default_nettype wire

[design/alle_dp.sv]
// Datapath: node store memories, walk pointer, head and allocation
// registers, condition flags and the output register. Depends on alle_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "array_linked_list_engine_macros.svh"

module alle_dp
    import alle_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_ctl     i_ctl,
    input  wire t_in_word i_in_word,
    input  wire logic     i_out_stall,
    output t_flags        o_flags,
    output logic          o_out_valid,
    output t_out_word     o_out_word
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [LINK_W-1:0] DEPTH_L  = LINK_W'(DEPTH);
    localparam logic [LINK_W-1:0] LAST_CNT = LINK_W'(DEPTH - 1);

    logic [31:0]       mem_val  [DEPTH];
    logic [LINK_W-1:0] mem_link [DEPTH];

    logic [LINK_W-1:0] r_head,  n_head;
    logic [LINK_W-1:0] r_alloc, n_alloc;
    logic [LINK_W-1:0] r_t,     n_t;
    logic [LINK_W-1:0] r_cnt,   n_cnt;
    logic [LINK_W-1:0] r_pv;
    logic [LINK_W-1:0] r_pos;
    logic [31:0]       r_val;
    logic [31:0]       r_rv;
    logic [LINK_W-1:0] r_rl;
    logic              r_out_valid;
    t_out_word         r_out_word, n_out_word;

    t_uword            uw;
    logic              ops;
    logic              out_load;
    logic              we_val, we_link;
    logic [IW-1:0]     w_addr;
    logic [IW-1:0]     r_addr;
    logic [LINK_W-1:0] w_link;

    assign uw  = i_ctl.uw;
    assign ops = i_ctl.do_ops;

    always_comb begin
        n_t = r_t;
        if (i_ctl.accept) begin
            n_t = r_head;
        end else if (ops) begin
            case (uw.t_sel)
                T_HEAD:  n_t = r_head;
                T_LINK:  n_t = r_rl;
                default: n_t = r_t;
            endcase
        end

        n_cnt = r_cnt;
        if (i_ctl.accept) begin
            n_cnt = '0;
        end else if (ops && uw.cnt_inc) begin
            n_cnt = r_cnt + LINK_W'(1);
        end

        n_head = r_head;
        if (ops) begin
            case (uw.h_sel)
                H_SLOT:  n_head = r_alloc;
                H_RL:    n_head = r_rl;
                default: n_head = r_head;
            endcase
        end

        n_alloc = (ops && uw.alloc_inc) ? r_alloc + LINK_W'(1) : r_alloc;

        case (uw.lsrc)
            L_HEAD:  w_link = r_head;
            L_RL:    w_link = r_rl;
            L_SLOT:  w_link = r_alloc;
            default: w_link = NULL_LINK;
        endcase

        we_val  = ops && (uw.wr == WR_NODE);
        we_link = ops && (uw.wr != WR_NONE);
        if (uw.wr == WR_NODE) begin
            w_addr = r_alloc[IW-1:0];
        end else if (uw.wa_pv) begin
            w_addr = r_pv[IW-1:0];
        end else begin
            w_addr = r_t[IW-1:0];
        end

        out_load   = ops && (uw.emit != E_NONE);
        n_out_word = r_out_word;
        case (uw.emit)
            E_STAT: begin
                n_out_word.read_value  = '0;
                n_out_word.status      = uw.status;
                n_out_word.last_of_run = 1'b1;
            end
            E_ELEM: begin
                n_out_word.read_value  = $signed(r_rv);
                n_out_word.status      = ST_OK;
                n_out_word.last_of_run = uw.last;
            end
            default: begin
                n_out_word = r_out_word;
            end
        endcase
    end

    // read port follows the next walk pointer, so r_rv/r_rl hold the node that r_t
    // points at, as it stood before any write in the same cycle
    assign r_addr = n_t[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_val) begin
            mem_val[w_addr] <= r_val;
        end
        if (we_link) begin
            mem_link[w_addr] <= w_link;
        end
        r_rv <= mem_val[r_addr];
        r_rl <= mem_link[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_LINK;
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_alloc <= n_alloc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_cnt <= n_cnt;
        // output word only changes when a new word is issued
        if (out_load) begin
            r_out_word <= n_out_word;
        end
        if (ops && uw.pv_load) begin
            r_pv <= r_t;
        end
        if (i_ctl.accept) begin
            r_val <= i_in_word.item_value;
            r_pos <= i_in_word.position;
        end
    end

    assign o_flags.full     = (r_alloc >= DEPTH_L);
    assign o_flags.tnull    = (r_t >= DEPTH_L);
    assign o_flags.nxtnull  = (r_rl >= DEPTH_L);
    assign o_flags.pos0     = (r_pos == '0);
    assign o_flags.walk_end = (r_t >= DEPTH_L) || ((r_cnt + LINK_W'(1)) == r_pos);
    assign o_flags.last     = (r_rl >= DEPTH_L) || (r_cnt == LAST_CNT);
    assign o_flags.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ALLE_ASSERT_NOW(a_no_alloc_when_full, ops && uw.alloc_inc, r_alloc < DEPTH_L, "slot allocated from a full store")
    `ALLE_ASSERT_NOW(a_head_in_range, 1'b1, (r_head < DEPTH_L) || (r_head == NULL_LINK), "head points outside the store")

endmodule

`default_nettype wire

[design/array_linked_list_engine.sv]
// Linked list engine. A command word is taken only while no command is in flight;
// a walk advances one link/cycle, but a read out walk waits while the output is held.
// Next command word is taken the cycle after the last result enters the output register.
// Synchronous active-low reset empties the list; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

// Top level. Ties the microcode sequencer to the node store datapath.
// Depends on alle_pkg, alle_seq and alle_dp.
//
// Commands: append, insert at position, delete at position, read out.
// Slots come from a rising allocation count and are never reused, so the
// store reports full after DEPTH allocations no matter how many deletes.
//
// Steps after the accept, for each outcome:
//   - full / empty errors: a condition check, then the status word
//   - range errors: the status word follows the walk
//   - append to an empty list or insert at the front: checks, then one write that emits the status
//   - append: walk to the tail, write the new node, link it in; insert: walk, range check, write, link
//   - read out: one word per node in list order, one per cycle while the output
//     register has room, with an idle step before the last word;
//     the walk shares the single read port of the node store
// The input is stalled whenever a command is in flight; an output word
// that the consumer stalls only holds the sequencer on its next emit.

module array_linked_list_engine
    import alle_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // command words
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    // result words
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_word     o_out_word
);

    t_ctl   ctl;    // decoded microword plus accept/issue strobes
    t_flags flags;  // branch conditions back from the datapath

    // sequencer: step counter and control store
    alle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_word.cmd),
        .i_flags    (flags),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    // datapath: node store, walk pointer, head, allocation count, output
    alle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
